>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, switched off while reset is held.
`define VCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define VCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/vcr_pkg.sv
`timescale 1ns / 1ps
package vcr_pkg;

  // Decoded region and raster geometry.
  localparam logic [15:0] REGION_START = 16'hD000;
  localparam logic [15:0] REGION_END   = 16'hD3FF;
  localparam logic [9:0]  TOTAL_LINES  = 10'd312;

  // Bad-line window and reset values.
  localparam logic [8:0] BAD_FIRST   = 9'h030;
  localparam logic [8:0] BAD_LAST    = 9'h0F7;
  localparam logic [2:0] BAD_PHASE   = 3'd6;
  localparam logic [7:0] CTRL1_RESET = 8'h18;
  localparam logic [7:0] CTRL2_RESET = 8'hC8;
  localparam logic [3:0] EDGE_RESET  = 4'hE;
  localparam logic [3:0] BACK0_RESET = 4'h6;

  // Register offsets inside the 64-byte window.
  localparam logic [5:0] OFF_SPR_LAST  = 6'h0F;
  localparam logic [5:0] OFF_XHIGH     = 6'h10;
  localparam logic [5:0] OFF_CTRL1     = 6'h11;
  localparam logic [5:0] OFF_RASTER    = 6'h12;
  localparam logic [5:0] OFF_PEN_X     = 6'h13;
  localparam logic [5:0] OFF_PEN_Y     = 6'h14;
  localparam logic [5:0] OFF_SPR_ON    = 6'h15;
  localparam logic [5:0] OFF_CTRL2     = 6'h16;
  localparam logic [5:0] OFF_Y_STRETCH = 6'h17;
  localparam logic [5:0] OFF_POINTER   = 6'h18;
  localparam logic [5:0] OFF_IRQ_FLAGS = 6'h19;
  localparam logic [5:0] OFF_IRQ_MASK  = 6'h1A;
  localparam logic [5:0] OFF_PRIORITY  = 6'h1B;
  localparam logic [5:0] OFF_MULTICOL  = 6'h1C;
  localparam logic [5:0] OFF_X_STRETCH = 6'h1D;
  localparam logic [5:0] OFF_EDGE      = 6'h20;
  localparam logic [5:0] OFF_BACK0     = 6'h21;
  localparam logic [5:0] OFF_BACK3     = 6'h24;
  localparam logic [5:0] OFF_SHARED0   = 6'h25;
  localparam logic [5:0] OFF_SHARED1   = 6'h26;
  localparam logic [5:0] OFF_OWN0      = 6'h27;
  localparam logic [5:0] OFF_OWN7      = 6'h2E;
  localparam logic [5:0] OFF_FF_A      = 6'h2F;
  localparam logic [5:0] OFF_FF_B      = 6'h30;
  localparam logic [5:0] OFF_FF_C      = 6'h31;
  localparam logic [5:0] OFF_ODD_FF    = 6'h33;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } vcr_req_t;

  typedef struct packed {
    logic [8:0] raster_now;
    logic       bad_line_flag;
    logic       irq_line;
    logic [7:0] read_data;
  } vcr_rsp_t;

endpackage

>>> rtl/video_chip_register_raster_irq_unit.sv
`timescale 1ns / 1ps
// Register file of a raster video controller with its line counter and raster
// interrupt. Each request is a bus read, a bus write or a raster line tick
// (in_tuser), and each gives exactly one result: the byte read, the irq line,
// the bad-line flag and the raster line after the request. A request is held
// in the input register, where the register file decodes it and updates its
// state, and then in the result register, and one request is taken every
// cycle while out_tready is high. The result register lets a new request
// enter while a result still waits.
`include "assert_macros.svh"
module video_chip_register_raster_irq_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // address[15:0], write_data[23:16]
  input  logic [1:0]  in_tuser,  // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata  // read_data[7:0], irq_line[8], bad_line_flag[9],
                                 // raster_now[18:10], zero fill[23:19]
);
  import vcr_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  vcr_req_t s1_req_r;
  logic     out_valid_r, out_valid_nxt;
  vcr_rsp_t out_rsp_r;
  vcr_rsp_t rsp;
  logic     s1_fire;
  logic     in_fire;
  logic     raster_in_range;
  logic     pipe_full;

  assign s1_fire = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  vcr_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .op_en (s1_fire),
    .req   (s1_req_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.func       <= in_tuser;
      s1_req_r.address    <= in_tdata[15:0];
      s1_req_r.write_data <= in_tdata[23:16];
    end
    if (s1_fire) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_rsp_r.raster_now, out_rsp_r.bad_line_flag,
                       out_rsp_r.irq_line, out_rsp_r.read_data};

  assign raster_in_range = {1'b0, out_rsp_r.raster_now} < TOTAL_LINES;
  assign pipe_full       = s1_valid_r && out_valid_r && !out_tready;

  `VCR_ASSERT(a_raster_bound, out_valid_r |-> raster_in_range, "raster line beyond the total")
  `VCR_ASSERT(a_advance, s1_fire |=> out_valid_r, "request lost between stages")
  `VCR_ASSERT(a_stall_cause, !in_tready |-> pipe_full, "input stalled while not full")
  `VCR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !(s1_valid_r || out_valid_r), "busy after reset")

endmodule

>>> rtl/vcr_regs.sv
`timescale 1ns / 1ps
module vcr_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              op_en,
  input  vcr_pkg::vcr_req_t req,
  output vcr_pkg::vcr_rsp_t rsp
);
  import vcr_pkg::*;

  logic [7:0] spr_x_r [8];
  logic [7:0] spr_x_nxt [8];
  logic [7:0] spr_y_r [8];
  logic [7:0] spr_y_nxt [8];
  logic [3:0] back_r [4];
  logic [3:0] back_nxt [4];
  logic [3:0] shared_r [2];
  logic [3:0] shared_nxt [2];
  logic [3:0] own_r [8];
  logic [3:0] own_nxt [8];
  logic [7:0] xhigh_r, xhigh_nxt;
  logic [7:0] ctrl1_r, ctrl1_nxt;
  logic [7:0] ctrl2_r, ctrl2_nxt;
  logic [7:0] cmp_r, cmp_nxt;
  logic [7:0] pen_x_r, pen_x_nxt;
  logic [7:0] pen_y_r, pen_y_nxt;
  logic [7:0] spr_on_r, spr_on_nxt;
  logic [7:0] y_str_r, y_str_nxt;
  logic [7:0] pointer_r, pointer_nxt;
  logic [3:0] irq_flags_r, irq_flags_nxt;
  logic [3:0] irq_mask_r, irq_mask_nxt;
  logic [7:0] prio_r, prio_nxt;
  logic [7:0] multi_r, multi_nxt;
  logic [7:0] x_str_r, x_str_nxt;
  logic [3:0] edge_col_r, edge_col_nxt;
  logic [8:0] line_r, line_nxt;
  logic       bad_r, bad_nxt;

  logic       in_win;
  logic [5:0] off;
  logic [2:0] spr_idx;
  logic [5:0] back_off, shared_off, own_off;
  logic [9:0] line_inc;
  logic [8:0] tick_line;
  logic [2:0] phase;
  logic [7:0] rd;
  func_t      fn;

  assign fn         = func_t'(req.func);
  assign in_win     = (req.address >= REGION_START) && (req.address <= REGION_END);
  assign off        = req.address[5:0];
  assign spr_idx    = off[3:1];
  assign back_off   = off - OFF_BACK0;
  assign shared_off = off - OFF_SHARED0;
  assign own_off    = off - OFF_OWN0;

  assign line_inc  = {1'b0, line_r} + 10'd1;
  assign tick_line = (line_inc >= TOTAL_LINES) ? 9'd0 : line_inc[8:0];
  assign phase     = tick_line[2:0] - ctrl1_r[2:0];

  // Read mux, taken from the state before the request.
  always_comb begin
    rd = 8'h00;
    case (off) inside
      [6'h00:OFF_SPR_LAST]: rd = off[0] ? spr_y_r[spr_idx] : spr_x_r[spr_idx];
      [OFF_BACK0:OFF_BACK3]: rd = {4'h0, back_r[back_off[1:0]]};
      OFF_SHARED0, OFF_SHARED1: rd = {4'h0, shared_r[shared_off[0]]};
      [OFF_OWN0:OFF_OWN7]: rd = {4'h0, own_r[own_off[2:0]]};
      OFF_XHIGH:     rd = xhigh_r;
      OFF_CTRL1:     rd = {line_r[8], ctrl1_r[6:0]};
      OFF_RASTER:    rd = line_r[7:0];
      OFF_PEN_X:     rd = pen_x_r;
      OFF_PEN_Y:     rd = pen_y_r;
      OFF_SPR_ON:    rd = spr_on_r;
      OFF_CTRL2:     rd = ctrl2_r;
      OFF_Y_STRETCH: rd = y_str_r;
      OFF_POINTER:   rd = pointer_r;
      OFF_IRQ_FLAGS: rd = {4'h0, irq_flags_r};
      OFF_IRQ_MASK:  rd = {4'h0, irq_mask_r};
      OFF_PRIORITY:  rd = prio_r;
      OFF_MULTICOL:  rd = multi_r;
      OFF_X_STRETCH: rd = x_str_r;
      OFF_EDGE:      rd = {4'h0, edge_col_r};
      OFF_FF_A, OFF_FF_B, OFF_FF_C: rd = 8'hFF;
      default: begin
        // Unused odd offsets at the top of the window float high.
        rd = ((off >= OFF_ODD_FF) && off[0]) ? 8'hFF : 8'h00;
      end
    endcase
  end

  always_comb begin
    spr_x_nxt     = spr_x_r;
    spr_y_nxt     = spr_y_r;
    back_nxt      = back_r;
    shared_nxt    = shared_r;
    own_nxt       = own_r;
    xhigh_nxt     = xhigh_r;
    ctrl1_nxt     = ctrl1_r;
    ctrl2_nxt     = ctrl2_r;
    cmp_nxt       = cmp_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    spr_on_nxt    = spr_on_r;
    y_str_nxt     = y_str_r;
    pointer_nxt   = pointer_r;
    irq_flags_nxt = irq_flags_r;
    irq_mask_nxt  = irq_mask_r;
    prio_nxt      = prio_r;
    multi_nxt     = multi_r;
    x_str_nxt     = x_str_r;
    edge_col_nxt  = edge_col_r;
    line_nxt      = line_r;
    bad_nxt       = bad_r;
    if (op_en) begin
      case (fn)
        FUNC_WRITE: begin
          if (in_win) begin
            case (off) inside
              [6'h00:OFF_SPR_LAST]: begin
                if (off[0]) begin
                  spr_y_nxt[spr_idx] = req.write_data;
                end else begin
                  spr_x_nxt[spr_idx] = req.write_data;
                end
              end
              [OFF_BACK0:OFF_BACK3]: back_nxt[back_off[1:0]] = req.write_data[3:0];
              OFF_SHARED0, OFF_SHARED1: shared_nxt[shared_off[0]] = req.write_data[3:0];
              [OFF_OWN0:OFF_OWN7]: own_nxt[own_off[2:0]] = req.write_data[3:0];
              OFF_XHIGH:     xhigh_nxt = req.write_data;
              OFF_CTRL1:     ctrl1_nxt = req.write_data;
              OFF_RASTER:    cmp_nxt = req.write_data;
              OFF_PEN_X:     pen_x_nxt = req.write_data;
              OFF_PEN_Y:     pen_y_nxt = req.write_data;
              OFF_SPR_ON:    spr_on_nxt = req.write_data;
              OFF_CTRL2:     ctrl2_nxt = req.write_data;
              OFF_Y_STRETCH: y_str_nxt = req.write_data;
              OFF_POINTER:   pointer_nxt = req.write_data;
              OFF_IRQ_FLAGS: irq_flags_nxt = irq_flags_r & ~req.write_data[3:0];
              OFF_IRQ_MASK:  irq_mask_nxt = req.write_data[3:0];
              OFF_PRIORITY:  prio_nxt = req.write_data;
              OFF_MULTICOL:  multi_nxt = req.write_data;
              OFF_X_STRETCH: x_str_nxt = req.write_data;
              OFF_EDGE:      edge_col_nxt = req.write_data[3:0];
              default: ;
            endcase
          end
        end
        FUNC_TICK: begin
          line_nxt = tick_line;
          bad_nxt  = ctrl1_r[4] && (tick_line >= BAD_FIRST) && (tick_line <= BAD_LAST) &&
                     (phase == BAD_PHASE);
          // Bit 8 of the compare line lives in control register one, bit 7.
          if (tick_line == {ctrl1_r[7], cmp_r}) begin
            irq_flags_nxt = irq_flags_r | 4'b0001;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        spr_x_r[i] <= 8'h00;
        spr_y_r[i] <= 8'h00;
        own_r[i]   <= 4'h0;
      end
      back_r[0]   <= BACK0_RESET;
      back_r[1]   <= 4'h0;
      back_r[2]   <= 4'h0;
      back_r[3]   <= 4'h0;
      shared_r[0] <= 4'h0;
      shared_r[1] <= 4'h0;
      xhigh_r     <= 8'h00;
      ctrl1_r     <= CTRL1_RESET;
      ctrl2_r     <= CTRL2_RESET;
      cmp_r       <= 8'h00;
      pen_x_r     <= 8'h00;
      pen_y_r     <= 8'h00;
      spr_on_r    <= 8'h00;
      y_str_r     <= 8'h00;
      pointer_r   <= 8'h00;
      irq_flags_r <= 4'h0;
      irq_mask_r  <= 4'h0;
      prio_r      <= 8'h00;
      multi_r     <= 8'h00;
      x_str_r     <= 8'h00;
      edge_col_r  <= EDGE_RESET;
      line_r      <= 9'd0;
      bad_r       <= 1'b0;
    end else begin
      spr_x_r     <= spr_x_nxt;
      spr_y_r     <= spr_y_nxt;
      own_r       <= own_nxt;
      back_r      <= back_nxt;
      shared_r    <= shared_nxt;
      xhigh_r     <= xhigh_nxt;
      ctrl1_r     <= ctrl1_nxt;
      ctrl2_r     <= ctrl2_nxt;
      cmp_r       <= cmp_nxt;
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      spr_on_r    <= spr_on_nxt;
      y_str_r     <= y_str_nxt;
      pointer_r   <= pointer_nxt;
      irq_flags_r <= irq_flags_nxt;
      irq_mask_r  <= irq_mask_nxt;
      prio_r      <= prio_nxt;
      multi_r     <= multi_nxt;
      x_str_r     <= x_str_nxt;
      edge_col_r  <= edge_col_nxt;
      line_r      <= line_nxt;
      bad_r       <= bad_nxt;
    end
  end

  // The result reports the state as it stands once the request has taken effect.
  always_comb begin
    rsp.read_data     = (fn == FUNC_READ && in_win) ? rd : 8'h00;
    rsp.irq_line      = |(irq_flags_nxt & irq_mask_nxt);
    rsp.bad_line_flag = bad_nxt;
    rsp.raster_now    = line_nxt;
  end

endmodule
